// File: rtl/bmft_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the block-mapped flash translation unit.
package bmft_pkg;

   localparam int SECTOR_W  = 10;
   localparam int PADDR_W   = 11;
   localparam int ERASE_W   = 6;

   typedef enum logic [2:0] {
      CMD_READ     = 3'd0,
      CMD_PROGRAM  = 3'd1,
      CMD_COPY     = 3'd2,
      CMD_ERASE    = 3'd3,
      CMD_UNMAPPED = 3'd4,
      CMD_NOFREE   = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_MAPWAIT,
      ST_SCAN,
      ST_PWWAIT,
      ST_COPY,
      ST_ERASE
   } state_type;

endpackage

// File: rtl/bmft_sector_split.sv
`timescale 1ns / 1ps
// Reciprocal-multiply split of a sector number into logical block and page offset.
module bmft_sector_split #(
   parameter int PAGES_PER_BLK = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  logic [bmft_pkg::SECTOR_W-1:0]        sector,
   output logic                                 done,
   output logic [bmft_pkg::SECTOR_W-1:0]        lbn,
   output logic [$clog2(PAGES_PER_BLK)-1:0]     off
);

   localparam int SW = bmft_pkg::SECTOR_W;
   localparam int OW = $clog2(PAGES_PER_BLK);
   localparam int SH = SW + OW;
   localparam int PW = 2 * SW + 1;
   // ceil(2^SH / PAGES_PER_BLK) gives an exact quotient for every SW-bit sector
   localparam logic [SW:0] RECIP =
      (SW + 1)'(((1 << SH) + PAGES_PER_BLK - 1) / PAGES_PER_BLK);
   localparam logic [SW-1:0] DIVISOR = SW'(PAGES_PER_BLK);

   logic                stage_ff, stage_in;
   logic                done_ff,  done_in;
   logic [SW-1:0]       sec_ff,   sec_in;
   logic [SW-1:0]       quot_ff,  quot_in;
   logic [OW-1:0]       rem_ff,   rem_in;
   logic [PW-1:0]       recip_prod;
   logic [PW-1:0]       quot_full;
   logic [SW-1:0]       back;
   logic [SW-1:0]       diff;

   always_comb begin
      recip_prod = PW'(sector) * PW'(RECIP);
      quot_full  = recip_prod >> SH;
      back       = quot_ff * DIVISOR;
      diff       = sec_ff - back;
      stage_in   = go;
      done_in    = stage_ff;
      sec_in     = sec_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      if (go) begin
         sec_in  = sector;
         quot_in = quot_full[SW-1:0];
      end
      if (stage_ff) begin
         rem_in = diff[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      sec_ff  <= sec_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign lbn  = quot_ff;
   assign off  = rem_ff;

endmodule

// File: rtl/block_mapped_flash_translation.sv
`timescale 1ns / 1ps
// Top level of the block-mapped flash translation unit.
//
// Request channel: a transaction is taken when start is high and busy is low. It carries
// req_action (0 read, 1 write) and req_logical_sector. Each transaction gives one or more
// flash commands on the rsp_ ports, each valid for exactly one cycle while rsp_strobe is
// high; rsp_last marks the final one. The receiver cannot hold results off.
// After reset the unit sweeps its block map and written-page memory, one entry a cycle,
// with busy high, then accepts requests.
// One transaction is handled at a time. The sector is split by a reciprocal multiply,
// then the map memory is read through a registered port.
// Block out of range, read, or write to an empty page of a mapped block: one result.
// Write to an unmapped block: the free-block scan reads one bitmap word a cycle; the
// single result comes later the higher the index of the block taken, and last of all
// when no block is free.
// Overwrite: PAGES_PER_BLK copy/program commands then one erase, one per cycle.
// busy falls in the cycle the final result is driven; the next transaction may go then.
module block_mapped_flash_translation #(
   parameter int DATA_BLOCKS   = 32,
   parameter int PAGES_PER_BLK = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [bmft_pkg::SECTOR_W-1:0]      req_logical_sector,
   output logic                               rsp_strobe,
   output logic [2:0]                         rsp_command,
   output logic [bmft_pkg::PADDR_W-1:0]       rsp_source_page,
   output logic [bmft_pkg::PADDR_W-1:0]       rsp_target_page,
   output logic [bmft_pkg::ERASE_W-1:0]       rsp_erase_block,
   output logic [bmft_pkg::SECTOR_W-1:0]      rsp_spare_tag,
   output logic                               rsp_last
);

   localparam int BW = $clog2(DATA_BLOCKS + 1);
   localparam int LW = $clog2(DATA_BLOCKS);
   localparam int OW = $clog2(PAGES_PER_BLK);
   localparam int MW = BW + bmft_pkg::PADDR_W;
   localparam logic [BW-1:0] LAST_BLK = BW'(DATA_BLOCKS);
   localparam logic [OW-1:0] LAST_PG  = OW'(PAGES_PER_BLK - 1);
   localparam logic [bmft_pkg::SECTOR_W:0] DB_EXT = (bmft_pkg::SECTOR_W + 1)'(DATA_BLOCKS);
   localparam logic [bmft_pkg::PADDR_W-1:0] SPARE_BASE_RST =
      bmft_pkg::PADDR_W'(DATA_BLOCKS * PAGES_PER_BLK);

   // map word: valid flag on top of the physical block number
   logic [BW:0]              map_mem [DATA_BLOCKS];
   logic [PAGES_PER_BLK-1:0] pw_mem  [DATA_BLOCKS + 1];

   bmft_pkg::state_type               state_ff, state_in;
   logic [BW-1:0]                     clr_ff, clr_in;
   logic                              act_ff, act_in;
   logic [bmft_pkg::SECTOR_W-1:0]     sector_ff, sector_in;
   logic [BW-1:0]                     spare_ff, spare_in;
   logic [bmft_pkg::PADDR_W-1:0]      spare_base_ff, spare_base_in;
   logic [BW-1:0]                     old_ff, old_in;
   logic [bmft_pkg::PADDR_W-1:0]      old_base_ff, old_base_in;
   logic [PAGES_PER_BLK-1:0]          old_bits_ff, old_bits_in;
   logic [OW-1:0]                     pg_ff, pg_in;
   logic [BW-1:0]                     scan_ff, scan_in;
   logic [BW-1:0]                     chk_idx_ff, chk_idx_in;
   logic                              chk_vld_ff, chk_vld_in;

   logic                              rsp_strobe_ff, rsp_strobe_in;
   bmft_pkg::cmd_type                 rsp_command_ff, rsp_command_in;
   logic [bmft_pkg::PADDR_W-1:0]      rsp_src_ff, rsp_src_in;
   logic [bmft_pkg::PADDR_W-1:0]      rsp_tgt_ff, rsp_tgt_in;
   logic [bmft_pkg::ERASE_W-1:0]      rsp_ers_ff, rsp_ers_in;
   logic [bmft_pkg::SECTOR_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              map_we;
   logic [LW-1:0]                     map_waddr;
   logic [BW:0]                       map_wdata;
   logic [BW:0]                       map_rd_ff;
   logic                              pw_we;
   logic [BW-1:0]                     pw_waddr;
   logic [PAGES_PER_BLK-1:0]          pw_wdata;
   logic [BW-1:0]                     pw_raddr;
   logic [PAGES_PER_BLK-1:0]          pw_rd_ff;

   logic                              div_kick_ff;
   logic                              div_done;
   logic [bmft_pkg::SECTOR_W-1:0]     lbn;
   logic [OW-1:0]                     off;
   logic [LW-1:0]                     lbn_idx;
   logic [PAGES_PER_BLK-1:0]          bit_mask;
   logic [BW-1:0]                     mul_blk;
   logic [MW-1:0]                     mul_full;
   logic [bmft_pkg::PADDR_W-1:0]      prod;

   bmft_sector_split #(
      .PAGES_PER_BLK (PAGES_PER_BLK)
   ) u_split (
      .clock  (clock),
      .reset  (reset),
      .go     (div_kick_ff),
      .sector (sector_ff),
      .done   (div_done),
      .lbn    (lbn),
      .off    (off)
   );

   assign lbn_idx  = lbn[LW-1:0];
   assign bit_mask = PAGES_PER_BLK'(1) << off;

   always_comb begin
      unique case (state_ff)
         bmft_pkg::ST_SCAN:    mul_blk = chk_idx_ff;
         bmft_pkg::ST_MAPWAIT: mul_blk = map_rd_ff[BW-1:0];
         default:              mul_blk = old_ff;
      endcase
      mul_full = MW'(mul_blk) * MW'(PAGES_PER_BLK);
      prod     = mul_full[bmft_pkg::PADDR_W-1:0];
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      act_in         = act_ff;
      sector_in      = sector_ff;
      spare_in       = spare_ff;
      spare_base_in  = spare_base_ff;
      old_in         = old_ff;
      old_base_in    = old_base_ff;
      old_bits_in    = old_bits_ff;
      pg_in          = pg_ff;
      scan_in        = scan_ff;
      chk_idx_in     = scan_ff;
      chk_vld_in     = (state_ff == bmft_pkg::ST_SCAN);
      rsp_strobe_in  = 1'b0;
      rsp_command_in = bmft_pkg::CMD_READ;
      rsp_src_in     = '0;
      rsp_tgt_in     = '0;
      rsp_ers_in     = '0;
      rsp_tag_in     = '0;
      rsp_last_in    = 1'b0;
      map_we         = 1'b0;
      map_waddr      = lbn_idx;
      map_wdata      = '0;
      pw_we          = 1'b0;
      pw_waddr       = old_ff;
      pw_wdata       = '0;
      pw_raddr       = scan_ff;

      unique case (state_ff)
         bmft_pkg::ST_CLEAR: begin
            pw_we     = 1'b1;
            pw_waddr  = clr_ff;
            map_we    = (clr_ff < LAST_BLK);
            map_waddr = LW'(clr_ff);
            if (clr_ff == LAST_BLK) begin
               state_in = bmft_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         bmft_pkg::ST_IDLE: begin
            if (start) begin
               act_in    = req_action;
               sector_in = req_logical_sector;
               state_in  = bmft_pkg::ST_DIV;
            end
         end
         bmft_pkg::ST_DIV: begin
            // sector_ff loaded at acceptance; divider starts in the cycle after
            if (div_done) begin
               state_in = bmft_pkg::ST_CHECK;
            end
         end
         bmft_pkg::ST_CHECK: begin
            if ({1'b0, lbn} >= DB_EXT) begin
               rsp_strobe_in  = 1'b1;
               rsp_command_in = act_ff ? bmft_pkg::CMD_NOFREE : bmft_pkg::CMD_UNMAPPED;
               rsp_last_in    = 1'b1;
               state_in       = bmft_pkg::ST_IDLE;
            end else begin
               state_in = bmft_pkg::ST_MAPWAIT;
            end
         end
         bmft_pkg::ST_MAPWAIT: begin
            if (!act_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
               if (map_rd_ff[BW]) begin
                  rsp_command_in = bmft_pkg::CMD_READ;
                  rsp_src_in     = prod + bmft_pkg::PADDR_W'(off);
               end else begin
                  rsp_command_in = bmft_pkg::CMD_UNMAPPED;
               end
               state_in = bmft_pkg::ST_IDLE;
            end else if (!map_rd_ff[BW]) begin
               scan_in  = '0;
               state_in = bmft_pkg::ST_SCAN;
            end else begin
               old_in   = map_rd_ff[BW-1:0];
               pw_raddr = map_rd_ff[BW-1:0];
               state_in = bmft_pkg::ST_PWWAIT;
            end
         end
         bmft_pkg::ST_SCAN: begin
            scan_in = (scan_ff == LAST_BLK) ? scan_ff : scan_ff + 1'b1;
            if (chk_vld_ff) begin
               if (chk_idx_ff != spare_ff && pw_rd_ff == '0) begin
                  map_we         = 1'b1;
                  map_wdata      = {1'b1, chk_idx_ff};
                  pw_we          = 1'b1;
                  pw_waddr       = chk_idx_ff;
                  pw_wdata       = bit_mask;
                  rsp_strobe_in  = 1'b1;
                  rsp_command_in = bmft_pkg::CMD_PROGRAM;
                  rsp_tgt_in     = prod + bmft_pkg::PADDR_W'(off);
                  rsp_tag_in     = sector_ff;
                  rsp_last_in    = 1'b1;
                  state_in       = bmft_pkg::ST_IDLE;
               end else if (chk_idx_ff == LAST_BLK) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_command_in = bmft_pkg::CMD_NOFREE;
                  rsp_last_in    = 1'b1;
                  state_in       = bmft_pkg::ST_IDLE;
               end
            end
         end
         bmft_pkg::ST_PWWAIT: begin
            old_base_in = prod;
            if ((pw_rd_ff & bit_mask) == '0) begin
               pw_we          = 1'b1;
               pw_waddr       = old_ff;
               pw_wdata       = pw_rd_ff | bit_mask;
               rsp_strobe_in  = 1'b1;
               rsp_command_in = bmft_pkg::CMD_PROGRAM;
               rsp_tgt_in     = prod + bmft_pkg::PADDR_W'(off);
               rsp_tag_in     = sector_ff;
               rsp_last_in    = 1'b1;
               state_in       = bmft_pkg::ST_IDLE;
            end else begin
               old_bits_in = pw_rd_ff | bit_mask;
               pg_in       = '0;
               state_in    = bmft_pkg::ST_COPY;
            end
         end
         bmft_pkg::ST_COPY: begin
            rsp_strobe_in = 1'b1;
            rsp_tgt_in    = spare_base_ff + bmft_pkg::PADDR_W'(pg_ff);
            if (pg_ff == off) begin
               rsp_command_in = bmft_pkg::CMD_PROGRAM;
               rsp_tag_in     = sector_ff;
            end else begin
               rsp_command_in = bmft_pkg::CMD_COPY;
               rsp_src_in     = old_base_ff + bmft_pkg::PADDR_W'(pg_ff);
            end
            // old block's bitmap is cleared early; nothing reads it before the erase
            if (pg_ff == '0) begin
               pw_we    = 1'b1;
               pw_waddr = old_ff;
            end
            if (pg_ff == LAST_PG) begin
               state_in = bmft_pkg::ST_ERASE;
            end else begin
               pg_in = pg_ff + 1'b1;
            end
         end
         bmft_pkg::ST_ERASE: begin
            pw_we          = 1'b1;
            pw_waddr       = spare_ff;
            pw_wdata       = old_bits_ff;
            map_we         = 1'b1;
            map_wdata      = {1'b1, spare_ff};
            spare_in       = old_ff;
            spare_base_in  = old_base_ff;
            rsp_strobe_in  = 1'b1;
            rsp_command_in = bmft_pkg::CMD_ERASE;
            rsp_ers_in     = bmft_pkg::ERASE_W'(old_ff);
            rsp_last_in    = 1'b1;
            state_in       = bmft_pkg::ST_IDLE;
         end
         default: begin
            state_in = bmft_pkg::ST_IDLE;
         end
      endcase
   end

   // divider kick: in the cycle after acceptance, once sector_ff holds the request
   always_ff @(posedge clock) begin
      if (reset) begin
         div_kick_ff <= 1'b0;
      end else begin
         div_kick_ff <= (state_ff == bmft_pkg::ST_IDLE) && start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bmft_pkg::ST_CLEAR;
         clr_ff        <= '0;
         spare_ff      <= LAST_BLK;
         spare_base_ff <= SPARE_BASE_RST;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         spare_ff      <= spare_in;
         spare_base_ff <= spare_base_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      act_ff         <= act_in;
      sector_ff      <= sector_in;
      old_ff         <= old_in;
      old_base_ff    <= old_base_in;
      old_bits_ff    <= old_bits_in;
      pg_ff          <= pg_in;
      scan_ff        <= scan_in;
      chk_idx_ff     <= chk_idx_in;
      rsp_command_ff <= rsp_command_in;
      rsp_src_ff     <= rsp_src_in;
      rsp_tgt_ff     <= rsp_tgt_in;
      rsp_ers_ff     <= rsp_ers_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[lbn_idx];
   end

   always_ff @(posedge clock) begin
      if (pw_we) begin
         pw_mem[pw_waddr] <= pw_wdata;
      end
      pw_rd_ff <= pw_mem[pw_raddr];
   end

   assign busy            = (state_ff != bmft_pkg::ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_command     = rsp_command_ff;
   assign rsp_source_page = rsp_src_ff;
   assign rsp_target_page = rsp_tgt_ff;
   assign rsp_erase_block = rsp_ers_ff;
   assign rsp_spare_tag   = rsp_tag_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      spare_ff <= LAST_BLK)
      else $error("spare block out of range");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == bmft_pkg::ST_COPY |-> pg_ff <= LAST_PG)
      else $error("page counter past end of block");

   assert property (@(posedge clock) disable iff (reset)
      map_we && state_ff == bmft_pkg::ST_SCAN |-> map_wdata[BW-1:0] != spare_ff)
      else $error("free scan mapped the spare block");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_command == bmft_pkg::CMD_ERASE |-> rsp_last)
      else $error("erase not the final command of its transaction");
`endif

endmodule

// File: tb/bmft_command_checker.sv
`timescale 1ns / 1ps
// Checker for the flash translation unit: predicts each request's flash commands and compares.
module bmft_command_checker #(
   parameter int DATA_BLOCKS   = 32,
   parameter int PAGES_PER_BLK = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_action,
   input  logic [bmft_pkg::SECTOR_W-1:0]      req_logical_sector,
   input  logic                               rsp_strobe,
   input  logic [2:0]                         rsp_command,
   input  logic [bmft_pkg::PADDR_W-1:0]       rsp_source_page,
   input  logic [bmft_pkg::PADDR_W-1:0]       rsp_target_page,
   input  logic [bmft_pkg::ERASE_W-1:0]       rsp_erase_block,
   input  logic [bmft_pkg::SECTOR_W-1:0]      rsp_spare_tag,
   input  logic                               rsp_last,
   output int                                 mismatches,
   output int                                 outstanding,
   output int                                 commands_checked,
   output int                                 overwrites
);

   localparam int PHYS_BLOCKS = DATA_BLOCKS + 1;

   typedef struct {
      bmft_pkg::cmd_type                command;
      logic [bmft_pkg::PADDR_W-1:0]     source_page;
      logic [bmft_pkg::PADDR_W-1:0]     target_page;
      logic [bmft_pkg::ERASE_W-1:0]     erase_block;
      logic [bmft_pkg::SECTOR_W-1:0]    spare_tag;
      logic                             last;
   } flash_cmd_type;

   int                        block_map [DATA_BLOCKS];
   logic                      map_valid [DATA_BLOCKS];
   int                        spare_block;
   logic [PAGES_PER_BLK-1:0]  page_written [PHYS_BLOCKS];
   flash_cmd_type             pending_commands [$];

   task automatic queue_command(input bmft_pkg::cmd_type command, input int source_page,
                                input int target_page, input int erase_block,
                                input int spare_tag, input logic last);
      flash_cmd_type item;
      item.command     = command;
      item.source_page = bmft_pkg::PADDR_W'(source_page);
      item.target_page = bmft_pkg::PADDR_W'(target_page);
      item.erase_block = bmft_pkg::ERASE_W'(erase_block);
      item.spare_tag   = bmft_pkg::SECTOR_W'(spare_tag);
      item.last        = last;
      pending_commands.push_back(item);
   endtask

   task automatic translate_request(input logic action,
                                    input logic [bmft_pkg::SECTOR_W-1:0] sector);
      int   lbn;
      int   page;
      int   phys;
      int   old_block;
      bit   found;
      lbn  = int'(sector) / PAGES_PER_BLK;
      page = int'(sector) % PAGES_PER_BLK;
      if (lbn >= DATA_BLOCKS) begin
         queue_command(action ? bmft_pkg::CMD_NOFREE : bmft_pkg::CMD_UNMAPPED,
                       0, 0, 0, 0, 1'b1);
      end else if (!action) begin
         if (map_valid[lbn])
            queue_command(bmft_pkg::CMD_READ, block_map[lbn] * PAGES_PER_BLK + page,
                          0, 0, 0, 1'b1);
         else
            queue_command(bmft_pkg::CMD_UNMAPPED, 0, 0, 0, 0, 1'b1);
      end else if (!map_valid[lbn] || !page_written[block_map[lbn]][page]) begin
         found = 1'b1;
         if (!map_valid[lbn]) begin
            found = 1'b0;
            for (phys = 0; phys < PHYS_BLOCKS && !found; phys++) begin
               if (phys != spare_block && page_written[phys] == '0) begin
                  found          = 1'b1;
                  block_map[lbn] = phys;
                  map_valid[lbn] = 1'b1;
               end
            end
         end
         if (found) begin
            page_written[block_map[lbn]][page] = 1'b1;
            queue_command(bmft_pkg::CMD_PROGRAM, 0, block_map[lbn] * PAGES_PER_BLK + page,
                          0, sector, 1'b1);
         end else begin
            queue_command(bmft_pkg::CMD_NOFREE, 0, 0, 0, 0, 1'b1);
         end
      end else begin
         // overwrite: rebuild the block in the spare, then retire the old one
         old_block = block_map[lbn];
         for (int p = 0; p < PAGES_PER_BLK; p++) begin
            if (p == page)
               queue_command(bmft_pkg::CMD_PROGRAM, 0, spare_block * PAGES_PER_BLK + p, 0,
                             sector, 1'b0);
            else
               queue_command(bmft_pkg::CMD_COPY, old_block * PAGES_PER_BLK + p,
                             spare_block * PAGES_PER_BLK + p, 0, 0, 1'b0);
         end
         page_written[spare_block]       = page_written[old_block];
         page_written[spare_block][page] = 1'b1;
         page_written[old_block]         = '0;
         block_map[lbn]                  = spare_block;
         spare_block                     = old_block;
         queue_command(bmft_pkg::CMD_ERASE, 0, 0, old_block, 0, 1'b1);
         overwrites++;
      end
   endtask

   always @(posedge clock) begin
      flash_cmd_type wanted;
      if (reset) begin
         for (int b = 0; b < DATA_BLOCKS; b++) begin
            block_map[b] = 0;
            map_valid[b] = 1'b0;
         end
         for (int b = 0; b < PHYS_BLOCKS; b++)
            page_written[b] = '0;
         spare_block = DATA_BLOCKS;
         pending_commands.delete();
      end else begin
         if (start === 1'b1 && busy === 1'b0)
            translate_request(req_action, req_logical_sector);
         if (rsp_strobe === 1'b1) begin
            if (pending_commands.size() == 0) begin
               if (mismatches < 10)
                  $display({"%0t: unexpected command cmd=%0d src=%0d dst=%0d erase=%0d",
                            " tag=%0d last=%0b"},
                           $realtime, rsp_command, rsp_source_page, rsp_target_page,
                           rsp_erase_block, rsp_spare_tag, rsp_last);
               mismatches++;
            end else begin
               wanted = pending_commands.pop_front();
               commands_checked++;
               if (rsp_command !== wanted.command || rsp_source_page !== wanted.source_page ||
                   rsp_target_page !== wanted.target_page ||
                   rsp_erase_block !== wanted.erase_block ||
                   rsp_spare_tag !== wanted.spare_tag || rsp_last !== wanted.last) begin
                  if (mismatches < 10) begin
                     $display("%0t: command mismatch", $realtime);
                     $display("   expected cmd=%0d src=%0d dst=%0d erase=%0d tag=%0d last=%0b",
                              wanted.command, wanted.source_page, wanted.target_page,
                              wanted.erase_block, wanted.spare_tag, wanted.last);
                     $display("   actual   cmd=%0d src=%0d dst=%0d erase=%0d tag=%0d last=%0b",
                              rsp_command, rsp_source_page, rsp_target_page,
                              rsp_erase_block, rsp_spare_tag, rsp_last);
                  end
                  mismatches++;
               end
            end
         end
      end
      outstanding = pending_commands.size();
   end

endmodule

// File: tb/block_mapped_flash_translation_test.sv
`timescale 1ns / 1ps
// Testbench top for the flash translation unit: drives sector requests and reports the verdict.
module block_mapped_flash_translation_test;

   localparam int   DATA_BLOCKS     = 32;
   localparam int   PAGES_PER_BLK   = 32;
   localparam int   RANDOM_REQUESTS = 260;
   localparam int   IDLE_LIMIT      = 2000;
   localparam int   DRAIN_CYCLES    = 60;
   localparam logic DO_READ         = 1'b0;
   localparam logic DO_WRITE        = 1'b1;

   logic                            clock              = 1'b0;
   logic                            reset              = 1'b1;
   logic                            start              = 1'b0;
   logic                            req_action         = 1'b0;
   logic [bmft_pkg::SECTOR_W-1:0]   req_logical_sector = '0;
   logic                            busy;
   logic                            rsp_strobe;
   logic [2:0]                      rsp_command;
   logic [bmft_pkg::PADDR_W-1:0]    rsp_source_page;
   logic [bmft_pkg::PADDR_W-1:0]    rsp_target_page;
   logic [bmft_pkg::ERASE_W-1:0]    rsp_erase_block;
   logic [bmft_pkg::SECTOR_W-1:0]   rsp_spare_tag;
   logic                            rsp_last;

   int mismatches;
   int outstanding;
   int commands_checked;
   int overwrites;
   int requests_sent = 0;
   int writes_sent   = 0;
   int idle_cycles   = 0;
   bit no_gap_phase  = 1'b0;
   int recent_writes [$];

   block_mapped_flash_translation #(
      .DATA_BLOCKS   (DATA_BLOCKS),
      .PAGES_PER_BLK (PAGES_PER_BLK)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_logical_sector (req_logical_sector),
      .rsp_strobe         (rsp_strobe),
      .rsp_command        (rsp_command),
      .rsp_source_page    (rsp_source_page),
      .rsp_target_page    (rsp_target_page),
      .rsp_erase_block    (rsp_erase_block),
      .rsp_spare_tag      (rsp_spare_tag),
      .rsp_last           (rsp_last)
   );

   bmft_command_checker #(
      .DATA_BLOCKS   (DATA_BLOCKS),
      .PAGES_PER_BLK (PAGES_PER_BLK)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_logical_sector (req_logical_sector),
      .rsp_strobe         (rsp_strobe),
      .rsp_command        (rsp_command),
      .rsp_source_page    (rsp_source_page),
      .rsp_target_page    (rsp_target_page),
      .rsp_erase_block    (rsp_erase_block),
      .rsp_spare_tag      (rsp_spare_tag),
      .rsp_last           (rsp_last),
      .mismatches         (mismatches),
      .outstanding        (outstanding),
      .commands_checked   (commands_checked),
      .overwrites         (overwrites)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_gap_phase || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(4, 1);
      else
         return $urandom_range(70, 15);
   endfunction

   // bias towards recently written sectors and a few hot blocks so overwrites are frequent
   function automatic logic [bmft_pkg::SECTOR_W-1:0] pick_sector();
      int r;
      int hot_blocks [3] = '{0, 1, DATA_BLOCKS - 1};
      r = $urandom_range(99);
      if (r < 35 && recent_writes.size() > 0)
         return bmft_pkg::SECTOR_W'(recent_writes[$urandom_range(recent_writes.size() - 1)]);
      else if (r < 60)
         return bmft_pkg::SECTOR_W'(hot_blocks[$urandom_range(2)] * PAGES_PER_BLK +
                                    $urandom_range(PAGES_PER_BLK - 1));
      else
         return bmft_pkg::SECTOR_W'($urandom_range(1023));
   endfunction

   task automatic issue(input logic action, input logic [bmft_pkg::SECTOR_W-1:0] sector);
      int gap;
      req_action         <= action;
      req_logical_sector <= sector;
      start              <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      requests_sent++;
      if (action == DO_WRITE) begin
         writes_sent++;
         recent_writes.push_back(int'(sector));
         if (recent_writes.size() > 48)
            void'(recent_writes.pop_front());
      end
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic                action;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      issue(DO_READ,  10'd0);
      issue(DO_WRITE, 10'd0);
      issue(DO_READ,  10'd0);
      issue(DO_WRITE, 10'd0);
      issue(DO_READ,  10'd0);
      issue(DO_WRITE, 10'd31);
      issue(DO_WRITE, 10'd31);
      issue(DO_READ,  10'd30);
      issue(DO_WRITE, 10'd1023);
      issue(DO_READ,  10'd1023);
      issue(DO_WRITE, 10'd992);
      issue(DO_WRITE, 10'd1023);
      issue(DO_READ,  10'd992);
      issue(DO_WRITE, 10'd512);
      issue(DO_WRITE, 10'd513);
      issue(DO_READ,  10'd511);
      issue(DO_WRITE, 10'd682);
      issue(DO_WRITE, 10'd341);
      issue(DO_READ,  10'd682);
      issue(DO_WRITE, 10'd682);
      issue(DO_WRITE, 10'd0);
      issue(DO_READ,  10'd341);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0)
            no_gap_phase = ($urandom_range(3) == 0);
         action = ($urandom_range(99) < 60) ? DO_WRITE : DO_READ;
         issue(action, pick_sector());
      end
      start <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Drove %0d sector requests (%0d writes, %0d of them block overwrites);",
               requests_sent, writes_sent, overwrites);
      $display("%0d flash commands checked, %0d mismatches.", commands_checked, mismatches);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
rtl/bmft_pkg.sv
rtl/bmft_sector_split.sv
rtl/block_mapped_flash_translation.sv
tb/bmft_command_checker.sv
tb/block_mapped_flash_translation_test.sv
